// ===== src/mvda_pkg.sv =====
package mvda_pkg;

	localparam int ROWS = 4;
	localparam int ELEM_W = 16;
	localparam int ACC_W = 32;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic retire;
		logic clear;
	} lane_ctrl_t;

endpackage

// ===== src/mvda_lane.sv =====
module mvda_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  mvda_pkg::lane_ctrl_t ctrl,
	input  mvda_pkg::elem_t     vec_even,
	input  mvda_pkg::elem_t     vec_odd,
	input  mvda_pkg::elem_t     row_even,
	input  mvda_pkg::elem_t     row_odd,
	output mvda_pkg::acc_t      sum
);

	mvda_pkg::acc_t prod_even;
	mvda_pkg::acc_t prod_odd;
	mvda_pkg::acc_t acc_q;
	mvda_pkg::acc_t acc_next;

	// products of a 16-bit signed pair fit in 32 bits
	assign prod_even = mvda_pkg::acc_t'(row_even) * mvda_pkg::acc_t'(vec_even);
	assign prod_odd  = mvda_pkg::acc_t'(row_odd) * mvda_pkg::acc_t'(vec_odd);

	// wraps modulo 2^32
	assign acc_next = acc_q + prod_even + prod_odd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.retire) begin
			acc_q <= ctrl.clear ? '0 : acc_next;
		end
	end

	assign sum = acc_next;

endmodule

// ===== src/matrix_vector_dot_accumulate_4row_top.sv =====
// four-row matrix-vector dot product accumulator, 16-bit signed lanes
// input channel (in_valid / in_stall): one column pair per transaction, the two
// vector elements and the matching elements of rows 0..3, plus last_pair
// each row adds row_even*vec_even + row_odd*vec_odd to a 32-bit wrapping sum
// output channel (out_valid / out_stall): one transaction per row block, carrying
// the four sums that include the last pair; the sums then restart from zero
// throughput: one column pair per cycle while in_stall is low; multiply and accumulate sit between
// the input register and the accumulator/result register
// out_valid rises once the accepted last-pair transaction has left the input
// register and been retired into the accumulate/result register
// while a result waits under out_stall, non-last pairs keep flowing and
// accumulating; only a further last pair waits in the input register, and
// then in_stall rises in the same cycle
// reset (arst_n low) empties every stage and clears the four accumulators (not the result register) to zero
module matrix_vector_dot_accumulate_4row_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  vec_even,
	input  logic signed [15:0]  vec_odd,
	input  logic signed [15:0]  row0_even,
	input  logic signed [15:0]  row0_odd,
	input  logic signed [15:0]  row1_even,
	input  logic signed [15:0]  row1_odd,
	input  logic signed [15:0]  row2_even,
	input  logic signed [15:0]  row2_odd,
	input  logic signed [15:0]  row3_even,
	input  logic signed [15:0]  row3_odd,
	input  logic                last_pair,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  sum_row0,
	output logic signed [31:0]  sum_row1,
	output logic signed [31:0]  sum_row2,
	output logic signed [31:0]  sum_row3
);

	mvda_pkg::elem_t vec_even_s1;
	mvda_pkg::elem_t vec_odd_s1;
	mvda_pkg::elem_t row_even_s1 [mvda_pkg::ROWS];
	mvda_pkg::elem_t row_odd_s1 [mvda_pkg::ROWS];
	logic            last_s1;
	logic            valid_s1;

	mvda_pkg::acc_t  lane_sum [mvda_pkg::ROWS];
	mvda_pkg::acc_t  sum_q [mvda_pkg::ROWS];
	logic            out_valid_q;

	logic            accept;
	logic            out_ready;
	logic            retire;
	mvda_pkg::lane_ctrl_t lane_ctrl;

	// handshake chain
	assign out_ready = !out_valid_q || !out_stall;
	assign retire    = valid_s1 && (!last_s1 || out_ready);
	assign in_stall  = valid_s1 && !retire;
	assign accept    = in_valid && !in_stall;

	assign lane_ctrl.retire = retire;
	assign lane_ctrl.clear  = last_s1;

	// input register
	always_ff @(posedge clk) begin
		if (accept) begin
			vec_even_s1    <= vec_even;
			vec_odd_s1     <= vec_odd;
			row_even_s1[0] <= row0_even;
			row_odd_s1[0]  <= row0_odd;
			row_even_s1[1] <= row1_even;
			row_odd_s1[1]  <= row1_odd;
			row_even_s1[2] <= row2_even;
			row_odd_s1[2]  <= row2_odd;
			row_even_s1[3] <= row3_even;
			row_odd_s1[3]  <= row3_odd;
			last_s1        <= last_pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	for (genvar k = 0; k < mvda_pkg::ROWS; k++) begin : g_lane
		mvda_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (lane_ctrl),
			.vec_even (vec_even_s1),
			.vec_odd  (vec_odd_s1),
			.row_even (row_even_s1[k]),
			.row_odd  (row_odd_s1[k]),
			.sum      (lane_sum[k])
		);
	end

	// result register
	always_ff @(posedge clk) begin
		if (retire && last_s1) begin
			sum_q <= lane_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign sum_row0  = sum_q[0];
	assign sum_row1  = sum_q[1];
	assign sum_row2  = sum_q[2];
	assign sum_row3  = sum_q[3];

`ifndef SYNTHESIS
	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(retire && last_s1))
		else $error("result raised without a retiring last pair");

	a_retire_valid: assert property (@(posedge clk) disable iff (!arst_n)
		retire |-> valid_s1)
		else $error("retire from an empty input stage");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall && valid_s1 && last_s1) |-> !retire)
		else $error("last pair retired over a waiting result");
`endif

endmodule
